### rtl/first_best_fit_block_allocator_unit_macros.svh
// assertion macros used by the allocator checker
`ifndef FIRST_BEST_FIT_BLOCK_ALLOCATOR_UNIT_MACROS_SVH
`define FIRST_BEST_FIT_BLOCK_ALLOCATOR_UNIT_MACROS_SVH

// assertion on a clock, switched off during reset
`define FBFA_ASSERT_RST(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// assertion on a clock that also holds during reset
`define FBFA_ASSERT_ALL(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/fbfa_pkg.sv
// shared types and constants of the block allocator
`default_nettype none
package fbfa_pkg;

   localparam int FBFA_MAX_BLOCKS = 16;
   localparam int FBFA_ADDR_BITS  = 16;
   localparam logic [15:0] FBFA_MSIZE_RESET = 16'd4096;

   // request kinds
   localparam logic [1:0] KIND_FIRST = 2'd0;
   localparam logic [1:0] KIND_BEST  = 2'd1;
   localparam logic [1:0] KIND_FREE  = 2'd2;
   localparam logic [1:0] KIND_PACK  = 2'd3;

   // result status codes
   localparam logic [2:0] STAT_OK      = 3'd0;
   localparam logic [2:0] STAT_NOMEM   = 3'd1;
   localparam logic [2:0] STAT_DUP     = 3'd2;
   localparam logic [2:0] STAT_NOHOLE  = 3'd3;
   localparam logic [2:0] STAT_NOTFND  = 3'd4;
   localparam logic [2:0] STAT_FULL    = 3'd5;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  blk_tag;
      logic [15:0] blk_len;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] block_start;
      logic [15:0] free_left;
   } rsp_type;

endpackage
`default_nettype wire

### rtl/fbfa_table_ram.sv
// block table storage: one write port, one registered read port
`default_nettype none
module fbfa_table_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 40
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, registered
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

### rtl/first_best_fit_block_allocator_unit.sv
// sequence: scan every block held in the table (a pack rewrites them as it goes), decide,
// then on a placement or release move the entries behind it and write the placed entry
// (a tail placement moves none); throughput: one request at a time, the next word is taken
// the cycle after the result is loaded into the output register, also while it waits there
// reset (synchronous, active high): table empty, memory size and free space 4096
`default_nettype none
module first_best_fit_block_allocator_unit import fbfa_pkg::*; #(
   parameter int MAX_BLOCKS = FBFA_MAX_BLOCKS,
   parameter int ADDR_BITS  = FBFA_ADDR_BITS
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire req_type     req_word,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output rsp_type          rsp_word,
   input  wire logic        csr_write_en,
   input  wire logic [15:0] csr_write_data
);

   localparam int NW = $clog2(MAX_BLOCKS + 1);
   localparam int IW = $clog2(MAX_BLOCKS);
   localparam int CW = (ADDR_BITS > 16) ? ADDR_BITS : 16;
   localparam int EW = 8 + 2 * ADDR_BITS;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SCAN   = 3'd1;
   localparam logic [2:0] ST_DECIDE = 3'd2;
   localparam logic [2:0] ST_SHIFT  = 3'd3;
   localparam logic [2:0] ST_PUT    = 3'd4;
   localparam logic [2:0] ST_DONE   = 3'd5;

   logic [2:0]           state_ff, state_in;
   req_type              req_ff, req_in;
   logic [NW-1:0]        count_ff, count_in;
   logic [15:0]          free_ff, free_in;
   logic [15:0]          msize_ff, msize_in;
   logic [NW-1:0]        iss_ff, iss_in;
   logic [NW-1:0]        rem_ff, rem_in;
   logic                 pv_ff, pv_in;
   logic [NW-1:0]        pidx_ff, pidx_in;
   logic [ADDR_BITS-1:0] run_ff, run_in;
   logic                 dup_ff, dup_in;
   logic                 hit_ff, hit_in;
   logic                 found_ff, found_in;
   logic [NW-1:0]        pick_ff, pick_in;
   logic [ADDR_BITS-1:0] pstart_ff, pstart_in;
   logic [CW-1:0]        best_ff, best_in;
   logic [ADDR_BITS-1:0] fsz_ff, fsz_in;
   rsp_type              res_ff, res_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_word_ff, rsp_word_in;

   logic                 wr_en;
   logic [IW-1:0]        wr_addr;
   logic [EW-1:0]        wr_data;
   logic [IW-1:0]        rd_addr;
   logic [EW-1:0]        rd_data;

   logic [7:0]           e_owner;
   logic [ADDR_BITS-1:0] e_begin, e_finish, e_size, e_hole;
   logic [ADDR_BITS-1:0] pack_finish, new_finish;
   logic [CW-1:0]        hole_ext, size_ext, tail_hole;
   logic                 is_alloc, fit, tail_fit, take_tail, fin_found;

   fbfa_table_ram #(
      .DEPTH (MAX_BLOCKS),
      .WIDTH (EW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // entry fields and per-entry arithmetic
   assign e_owner     = rd_data[EW-1 -: 8];
   assign e_begin     = rd_data[2*ADDR_BITS-1:ADDR_BITS];
   assign e_finish    = rd_data[ADDR_BITS-1:0];
   assign e_size      = (e_finish >= e_begin) ? (e_finish - e_begin) : '0;
   assign e_hole      = (e_begin >= run_ff) ? (e_begin - run_ff) : '0;
   assign hole_ext    = CW'(e_hole);
   assign size_ext    = CW'(req_ff.blk_len);
   assign fit         = size_ext <= hole_ext;
   assign pack_finish = ADDR_BITS'(CW'(run_ff) + CW'(e_size));
   assign new_finish  = ADDR_BITS'(CW'(pstart_ff) + size_ext);
   assign is_alloc    = (req_ff.kind == KIND_FIRST) || (req_ff.kind == KIND_BEST);

   // tail hole from the last block to the end of memory
   assign tail_hole = (CW'(msize_ff) >= CW'(run_ff)) ? (CW'(msize_ff) - CW'(run_ff)) : '0;
   assign tail_fit  = size_ext <= tail_hole;
   assign take_tail = tail_fit &&
                      ((req_ff.kind == KIND_FIRST) ? !found_ff
                                                   : (!found_ff || tail_hole < best_ff));
   assign fin_found = found_ff || take_tail;

   // table write port
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = pidx_ff[IW-1:0];
      wr_data = rd_data;
      if (state_ff == ST_SCAN && pv_ff && req_ff.kind == KIND_PACK) begin
         wr_en   = 1'b1;
         wr_data = {e_owner, run_ff, pack_finish};
      end else if (state_ff == ST_SHIFT && pv_ff) begin
         wr_en   = 1'b1;
         wr_addr = is_alloc ? IW'(pidx_ff + NW'(1)) : IW'(pidx_ff - NW'(1));
      end else if (state_ff == ST_PUT && is_alloc) begin
         wr_en   = 1'b1;
         wr_addr = pick_ff[IW-1:0];
         wr_data = {req_ff.blk_tag, pstart_ff, new_finish};
      end
   end

   assign rd_addr = iss_ff[IW-1:0];

   // request sequencer
   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      count_in     = count_ff;
      free_in      = free_ff;
      msize_in     = msize_ff;
      iss_in       = iss_ff;
      rem_in       = rem_ff;
      pv_in        = 1'b0;
      pidx_in      = pidx_ff;
      run_in       = run_ff;
      dup_in       = dup_ff;
      hit_in       = hit_ff;
      found_in     = found_ff;
      pick_in      = pick_ff;
      pstart_in    = pstart_ff;
      best_in      = best_ff;
      fsz_in       = fsz_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_word_in  = rsp_word_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in   = req_word;
               iss_in   = '0;
               run_in   = '0;
               dup_in   = 1'b0;
               hit_in   = 1'b0;
               found_in = 1'b0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // issue the next read
            if (iss_ff < count_ff) begin
               pv_in   = 1'b1;
               pidx_in = iss_ff;
               iss_in  = iss_ff + NW'(1);
            end else if (!pv_ff) begin
               state_in = ST_DECIDE;
            end
            // look at the entry that came back
            if (pv_ff) begin
               if (is_alloc) begin
                  if (e_owner == req_ff.blk_tag) dup_in = 1'b1;
                  if (fit && ((req_ff.kind == KIND_FIRST) ? !found_ff
                                                          : (!found_ff || hole_ext < best_ff))) begin
                     found_in  = 1'b1;
                     pick_in   = pidx_ff;
                     pstart_in = run_ff;
                     best_in   = hole_ext;
                  end
                  run_in = e_finish;
               end else if (req_ff.kind == KIND_FREE) begin
                  if (!hit_ff && e_owner == req_ff.blk_tag) begin
                     hit_in  = 1'b1;
                     pick_in = pidx_ff;
                     fsz_in  = e_size;
                  end
               end else begin
                  run_in = pack_finish;
               end
            end
         end
         ST_DECIDE: begin
            res_in.block_start = '0;
            res_in.free_left   = free_ff;
            res_in.status      = STAT_OK;
            state_in           = ST_DONE;
            if (is_alloc) begin
               if (req_ff.blk_len > free_ff) begin
                  res_in.status = STAT_NOMEM;
               end else if (dup_ff) begin
                  res_in.status = STAT_DUP;
               end else if (count_ff == NW'(MAX_BLOCKS)) begin
                  res_in.status = STAT_FULL;
               end else if (!fin_found) begin
                  res_in.status = STAT_NOHOLE;
               end else begin
                  if (take_tail) begin
                     pick_in   = count_ff;
                     pstart_in = run_ff;
                     state_in  = ST_PUT;
                  end else begin
                     iss_in   = count_ff - NW'(1);
                     rem_in   = count_ff - pick_ff;
                     state_in = ST_SHIFT;
                  end
               end
            end else if (req_ff.kind == KIND_FREE) begin
               if (!hit_ff) begin
                  res_in.status = STAT_NOTFND;
               end else begin
                  iss_in   = pick_ff + NW'(1);
                  rem_in   = count_ff - pick_ff - NW'(1);
                  state_in = ST_SHIFT;
               end
            end
         end
         ST_SHIFT: begin
            // move entries one slot up (allocate) or down (free)
            if (rem_ff != '0) begin
               pv_in   = 1'b1;
               pidx_in = iss_ff;
               iss_in  = is_alloc ? iss_ff - NW'(1) : iss_ff + NW'(1);
               rem_in  = rem_ff - NW'(1);
            end else if (!pv_ff) begin
               state_in = ST_PUT;
            end
         end
         ST_PUT: begin
            res_in.status = STAT_OK;
            if (is_alloc) begin
               count_in           = count_ff + NW'(1);
               free_in            = free_ff - req_ff.blk_len;
               res_in.block_start = 16'(CW'(pstart_ff));
               res_in.free_left   = free_ff - req_ff.blk_len;
            end else begin
               count_in           = count_ff - NW'(1);
               free_in            = 16'(CW'(free_ff) + CW'(fsz_ff));
               res_in.block_start = '0;
               res_in.free_left   = 16'(CW'(free_ff) + CW'(fsz_ff));
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_word_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // memory size write empties the table
      if (csr_write_en) begin
         msize_in = csr_write_data;
         free_in  = csr_write_data;
         count_in = '0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         free_ff      <= FBFA_MSIZE_RESET;
         msize_ff     <= FBFA_MSIZE_RESET;
         pv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         free_ff      <= free_in;
         msize_ff     <= msize_in;
         pv_ff        <= pv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      iss_ff      <= iss_in;
      rem_ff      <= rem_in;
      pidx_ff     <= pidx_in;
      run_ff      <= run_in;
      dup_ff      <= dup_in;
      hit_ff      <= hit_in;
      found_ff    <= found_in;
      pick_ff     <= pick_in;
      pstart_ff   <= pstart_in;
      best_ff     <= best_in;
      fsz_ff      <= fsz_in;
      res_ff      <= res_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule
`default_nettype wire

### rtl/fbfa_checker.sv
// port checker for the block allocator and its bind
`default_nettype none
`include "first_best_fit_block_allocator_unit_macros.svh"
module fbfa_checker import fbfa_pkg::*; (
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_stall,
   input wire logic    rsp_valid,
   input wire logic    rsp_stall,
   input wire rsp_type rsp_word
);

   // a stalled result word stays and holds
   `FBFA_ASSERT_RST(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid, "rsp dropped")
   `FBFA_ASSERT_RST(a_rsp_stable, clock, reset, rsp_valid && rsp_stall |=> $stable(rsp_word), "rsp changed")

   // an accepted request keeps the input busy next cycle
   `FBFA_ASSERT_RST(a_busy, clock, reset, req_valid && !req_stall |=> req_stall, "not busy")

   // start zero on failure
   `FBFA_ASSERT_RST(a_start0, clock, reset, rsp_valid && rsp_word.status != STAT_OK |-> rsp_word.block_start == 16'd0, "start on fail")

   // nothing pending out of reset
   `FBFA_ASSERT_ALL(a_reset, clock, $past(reset) |-> !rsp_valid && !req_stall, "reset state")

endmodule

bind first_best_fit_block_allocator_unit fbfa_checker u_fbfa_checker (.*);
`default_nettype wire

### tb/sv/tb_first_best_fit_block_allocator_unit.sv
// self-checking testbench of the first-fit / best-fit block allocator
`default_nettype none
module tb_first_best_fit_block_allocator_unit;
   import fbfa_pkg::*;

   localparam int TABLE_DEPTH = FBFA_MAX_BLOCKS;
   localparam int CYCLE_LIMIT = 1000000;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_type     req_word;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_type     rsp_word;
   logic        csr_write_en;
   logic [15:0] csr_write_data;

   first_best_fit_block_allocator_unit DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_word(rsp_word),
      .csr_write_en(csr_write_en), .csr_write_data(csr_write_data)
   );

   // shadow allocator state
   logic [7:0]  shadow_owner [TABLE_DEPTH];
   logic [15:0] shadow_begin [TABLE_DEPTH];
   logic [15:0] shadow_finish[TABLE_DEPTH];
   int          shadow_count;
   logic [15:0] shadow_free;
   logic [15:0] shadow_msize;

   req_type     pending_words[$];
   rsp_type     expected_results[$];
   int          error_count;
   int          cycle_count;
   int          words_sent;
   int          results_seen;
   int          ok_allocs;
   int          failed_reqs;
   int          hold_off_cycles;
   bit          hold_off_request;
   bit          hold_off_started;
   int          send_gap;
   bit          sent_flag;
   int          stall_left;

   // clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic logic [15:0] gap_start(int k);
      return (k == 0) ? 16'd0 : shadow_finish[k-1];
   endfunction

   function automatic logic [15:0] gap_size(int k);
      logic [15:0] s;
      logic [15:0] e;
      s = gap_start(k);
      e = (k < shadow_count) ? shadow_begin[k] : shadow_msize;
      return (e >= s) ? e - s : 16'd0;
   endfunction

   function automatic void clear_shadow(logic [15:0] msize);
      shadow_msize = msize;
      shadow_count = 0;
      shadow_free  = msize;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         shadow_owner[i] = '0; shadow_begin[i] = '0; shadow_finish[i] = '0;
      end
   endfunction

   // compute the result of one request and update the shadow table
   function automatic rsp_type allocate_step(req_type w);
      rsp_type     r;
      bit          dup;
      bit          found;
      int          pick;
      int          pos;
      logic [15:0] best;
      logic [15:0] h;
      logic [15:0] sz;
      logic [15:0] next_addr;
      r = '0;
      r.status = STAT_OK;
      dup = 0; found = 0; pick = 0; pos = 0; best = '0;
      if (w.kind == KIND_FIRST || w.kind == KIND_BEST) begin
         for (int i = 0; i < shadow_count; i++)
            if (shadow_owner[i] == w.blk_tag) dup = 1;
         if (w.blk_len > shadow_free) r.status = STAT_NOMEM;
         else if (dup) r.status = STAT_DUP;
         else if (shadow_count >= TABLE_DEPTH) r.status = STAT_FULL;
         else begin
            for (int i = 0; i <= shadow_count; i++) begin
               h = gap_size(i);
               if (w.blk_len <= h) begin
                  if (w.kind == KIND_FIRST) begin
                     if (!found) begin found = 1; pick = i; end
                  end else if (!found || h < best) begin
                     found = 1; pick = i; best = h;
                  end
               end
            end
            if (!found) r.status = STAT_NOHOLE;
            else begin
               r.block_start = gap_start(pick);
               for (int i = shadow_count; i > pick; i--) begin
                  shadow_owner[i]  = shadow_owner[i-1];
                  shadow_begin[i]  = shadow_begin[i-1];
                  shadow_finish[i] = shadow_finish[i-1];
               end
               shadow_owner[pick]  = w.blk_tag;
               shadow_begin[pick]  = r.block_start;
               shadow_finish[pick] = r.block_start + w.blk_len;
               shadow_count++;
               shadow_free -= w.blk_len;
            end
         end
      end else if (w.kind == KIND_FREE) begin
         for (int i = shadow_count - 1; i >= 0; i--)
            if (shadow_owner[i] == w.blk_tag) begin found = 1; pos = i; end
         if (!found) r.status = STAT_NOTFND;
         else begin
            sz = (shadow_finish[pos] >= shadow_begin[pos]) ?
                 shadow_finish[pos] - shadow_begin[pos] : 16'd0;
            for (int i = pos; i + 1 < shadow_count; i++) begin
               shadow_owner[i]  = shadow_owner[i+1];
               shadow_begin[i]  = shadow_begin[i+1];
               shadow_finish[i] = shadow_finish[i+1];
            end
            shadow_count--;
            shadow_free += sz;
         end
      end else begin
         next_addr = '0;
         for (int i = 0; i < shadow_count; i++) begin
            sz = (shadow_finish[i] >= shadow_begin[i]) ?
                 shadow_finish[i] - shadow_begin[i] : 16'd0;
            shadow_begin[i]  = next_addr;
            shadow_finish[i] = next_addr + sz;
            next_addr = shadow_finish[i];
         end
      end
      r.free_left = shadow_free;
      return r;
   endfunction

   // accepted words feed the predictor at the rising edge
   always @(posedge clock) begin : acceptance
      if (!reset && req_valid && !req_stall) begin
         expected_results.push_back(allocate_step(req_word));
         words_sent <= words_sent + 1;
      end
   end

   // driver: lowers or advances valid at the falling edge
   always @(negedge clock) begin : driver
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  <= $urandom_range(0, 16);
      end else if (req_valid && !sent_flag) begin
         // holding the current word
      end else if (send_gap > 0) begin
         req_valid <= 1'b0;
         send_gap  <= send_gap - 1;
      end else if (pending_words.size() > 0) begin
         req_word  <= pending_words.pop_front();
         req_valid <= 1'b1;
         send_gap  <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
      end else begin
         req_valid <= 1'b0;
      end
   end

   // remember whether the offered word was accepted at the last rising edge
   always @(posedge clock) sent_flag <= reset ? 1'b0 : (req_valid && !req_stall);

   // long hold-off counter on the result side
   always @(negedge clock) begin : hold_off
      if (reset) begin
         hold_off_cycles  <= 0;
         hold_off_started <= 1'b0;
      end else if (hold_off_request && !hold_off_started) begin
         hold_off_cycles  <= 400;
         hold_off_started <= 1'b1;
      end else if (hold_off_cycles > 0) begin
         hold_off_cycles <= hold_off_cycles - 1;
      end
   end

   // receiver stall, with one long hold-off
   always @(negedge clock) begin : receiver
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (hold_off_cycles > 0) begin
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else begin
         rsp_stall  <= 1'b0;
         if (rsp_valid && ($urandom_range(0, 2) == 0)) stall_left <= $urandom_range(0, 16);
      end
   end

   // monitor: compare each result word with the oldest expectation
   always @(posedge clock) begin : monitor
      rsp_type exp_r;
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen <= results_seen + 1;
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result word %h", $time, rsp_word);
            error_count <= error_count + 1;
         end else begin
            exp_r = expected_results.pop_front();
            if (exp_r.status == STAT_OK && exp_r.block_start != 0) ok_allocs <= ok_allocs + 1;
            if (exp_r.status != STAT_OK) failed_reqs <= failed_reqs + 1;
            if (rsp_word.status !== exp_r.status ||
                rsp_word.block_start !== exp_r.block_start ||
                rsp_word.free_left !== exp_r.free_left) begin
               $display("%0t: expected status %0d start %0d free %0d, got %0d %0d %0d",
                  $time, exp_r.status, exp_r.block_start, exp_r.free_left,
                  rsp_word.status, rsp_word.block_start, rsp_word.free_left);
               error_count <= error_count + 1;
            end
         end
      end
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("first_best_fit_block_allocator_unit: mismatch");
         $finish;
      end
   end

   function automatic req_type make_word(logic [1:0] k, logic [7:0] id, logic [15:0] sz);
      req_type w;
      w.kind = k; w.blk_tag = id; w.blk_len = sz;
      return w;
   endfunction

   // wait until every queued word was accepted and answered
   task automatic drain();
      while (pending_words.size() > 0 || req_valid || expected_results.size() > 0)
         @(posedge clock);
      repeat (2 * TABLE_DEPTH + 8) @(posedge clock);
   endtask

   task automatic write_msize(logic [15:0] msize);
      @(negedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= msize;
      @(negedge clock);
      csr_write_en   <= 1'b0;
      clear_shadow(msize);
   endtask

   // random word: mostly allocations with ids from a small pool
   function automatic req_type random_word(logic [15:0] msize);
      logic [1:0]  k;
      logic [15:0] sz;
      logic [7:0]  id;
      int          sel;
      sel = $urandom_range(0, 99);
      k = (sel < 35) ? KIND_FIRST : (sel < 70) ? KIND_BEST : (sel < 93) ? KIND_FREE : KIND_PACK;
      sel = $urandom_range(0, 9);
      if (sel == 0) sz = 16'($urandom);
      else if (sel == 1) sz = '0;
      else sz = 16'($urandom_range(0, (msize >> 3) + 1));
      id = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 23));
      return make_word(k, id, sz);
   endfunction

   // stimulus
   initial begin
      logic [15:0] sizes[6];
      reset = 1'b1;
      csr_write_en = 1'b0;
      csr_write_data = '0;
      hold_off_request = 1'b0;
      error_count = 0; cycle_count = 0; words_sent = 0; results_seen = 0;
      ok_allocs = 0; failed_reqs = 0;
      clear_shadow(FBFA_MSIZE_RESET);
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: extremes, every kind, status order, zero size, best-fit ties
      pending_words.push_back(make_word(KIND_FIRST, 8'd0, 16'd0));
      pending_words.push_back(make_word(KIND_FIRST, 8'd255, 16'd100));
      pending_words.push_back(make_word(KIND_FIRST, 8'd0, 16'd5));
      pending_words.push_back(make_word(KIND_FIRST, 8'd1, 16'hFFFF));
      pending_words.push_back(make_word(KIND_BEST, 8'd2, 16'd300));
      pending_words.push_back(make_word(KIND_FREE, 8'd255, 16'hFFFF));
      pending_words.push_back(make_word(KIND_FREE, 8'd77, 16'd0));
      pending_words.push_back(make_word(KIND_BEST, 8'd3, 16'd50));
      pending_words.push_back(make_word(KIND_FIRST, 8'd4, 16'd60));
      pending_words.push_back(make_word(KIND_PACK, 8'd0, 16'd0));
      pending_words.push_back(make_word(KIND_BEST, 8'd5, 16'd3696));
      pending_words.push_back(make_word(KIND_FIRST, 8'd6, 16'd1));
      for (int i = 0; i < 10; i++)
         pending_words.push_back(make_word(KIND_FIRST, 8'd10 + i[7:0], 16'd0));
      pending_words.push_back(make_word(KIND_BEST, 8'd99, 16'd0));
      pending_words.push_back(make_word(KIND_PACK, 8'hFF, 16'hFFFF));
      drain();

      // long hold-off on the result side while words keep coming
      hold_off_request = 1'b1;
      for (int i = 0; i < 40; i++) pending_words.push_back(random_word(16'd4096));
      drain();

      sizes = '{16'd0, 16'hFFFF, 16'd64, 16'd1000, 16'd4096, 16'd200};
      foreach (sizes[p]) begin
         write_msize(sizes[p]);
         for (int i = 0; i < 250; i++) pending_words.push_back(random_word(sizes[p]));
         drain();
      end

      $display("covered %0d words, %0d results, memory sizes 0 to 65535, a long result hold-off",
         words_sent, results_seen);
      $display("%0d successful nonzero placements, %0d refused requests", ok_allocs, failed_reqs);
      if (error_count == 0) $display("first_best_fit_block_allocator_unit: match");
      else $display("first_best_fit_block_allocator_unit: mismatch");
      $finish;
   end
endmodule
`default_nettype wire
